// File: sv/g726_pkg.sv
// Shared types, constants and table functions for the G.726 32 kbit/s ADPCM codec.
// No dependencies; g726_fmul, the top level and the testbench import this package.
package g726_pkg;

   // Request to and answer from the shared coefficient-times-float product unit
   typedef struct packed {
      logic              valid;
      logic [2:0]        tag;
      logic signed [15:0] coef;
      logic [10:0]       fl;
   } fmul_req_type;

   typedef struct packed {
      logic              valid;
      logic [2:0]        tag;
      logic signed [15:0] prod;
   } fmul_rsp_type;

   localparam logic [18:0] SLOW_RESET = 19'd34816;
   localparam logic [12:0] FAST_RESET = 13'd544;
   localparam logic [12:0] Y_MIN      = 13'd544;
   localparam logic [12:0] Y_MAX      = 13'd5120;
   localparam logic [10:0] FLOAT_ONE  = 11'h020;
   localparam logic [9:0]  SPEED_TONE = 10'd256;
   localparam logic [2:0]  TAG_LAST_ZERO = 3'd5;
   localparam logic [2:0]  TAG_LAST      = 3'd7;

   // Length of a value: number of k in 0..14 with v >= 2^k
   function automatic logic [3:0] bit_len(input logic [15:0] v);
      logic [3:0] r;
      r = '0;
      for (int k = 0; k < 15; k++) begin
         if (v >= (16'd1 << k)) r = 4'(k + 1);
      end
      return r;
   endfunction

   // Magnitude to 11-bit float: sign, 4-bit exponent, 6-bit mantissa
   function automatic logic [10:0] to_float(input logic [14:0] mag, input logic neg);
      logic [3:0]  e;
      logic [20:0] m;
      logic [10:0] f;
      e = bit_len({1'b0, mag});
      m = {mag, 6'b0} >> e;
      if (mag == '0) f = FLOAT_ONE;
      else f = {1'b0, e, m[5:0]};
      f[10] = neg;
      return f;
   endfunction

   function automatic logic signed [11:0] dqln_val(input logic [3:0] code);
      logic signed [11:0] r;
      unique case (code)
         4'd0, 4'd15: r = -12'sd2048;
         4'd1, 4'd14: r = 12'sd4;
         4'd2, 4'd13: r = 12'sd135;
         4'd3, 4'd12: r = 12'sd213;
         4'd4, 4'd11: r = 12'sd273;
         4'd5, 4'd10: r = 12'sd323;
         4'd6, 4'd9:  r = 12'sd373;
         default:     r = 12'sd425;
      endcase
      return r;
   endfunction

   function automatic logic signed [11:0] wi_val(input logic [3:0] code);
      logic signed [11:0] r;
      unique case (code)
         4'd0, 4'd15: r = -12'sd12;
         4'd1, 4'd14: r = 12'sd18;
         4'd2, 4'd13: r = 12'sd41;
         4'd3, 4'd12: r = 12'sd64;
         4'd4, 4'd11: r = 12'sd112;
         4'd5, 4'd10: r = 12'sd198;
         4'd6, 4'd9:  r = 12'sd355;
         default:     r = 12'sd1122;
      endcase
      return r;
   endfunction

   function automatic logic [11:0] fi_val(input logic [3:0] code);
      logic [11:0] r;
      unique case (code)
         4'd3, 4'd4, 4'd5, 4'd10, 4'd11, 4'd12: r = 12'h200;
         4'd6, 4'd9:                            r = 12'h600;
         4'd7, 4'd8:                            r = 12'hE00;
         default:                               r = 12'h000;
      endcase
      return r;
   endfunction

   function automatic logic signed [11:0] qtab_val(input logic [2:0] k);
      logic signed [11:0] r;
      unique case (k)
         3'd0:    r = -12'sd124;
         3'd1:    r = 12'sd80;
         3'd2:    r = 12'sd178;
         3'd3:    r = 12'sd246;
         3'd4:    r = 12'sd300;
         3'd5:    r = 12'sd349;
         default: r = 12'sd400;
      endcase
      return r;
   endfunction

endpackage

// File: sv/g726_if.sv
// Valid/ready channel interfaces for the codec's item input and result output.
// Depends on nothing; used by the top level and its surroundings.
interface g726_req_if;
   logic               valid;
   logic               ready;
   logic [7:0]         code_byte;
   logic signed [15:0] sample_first;
   logic signed [15:0] sample_second;
   logic               restart;
   logic               end_of_block;

   modport source (output valid, code_byte, sample_first, sample_second, restart,
                   end_of_block, input ready);
   modport sink   (input valid, code_byte, sample_first, sample_second, restart,
                   end_of_block, output ready);
endinterface

interface g726_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_out;
   logic [7:0]         code_byte_out;
   logic               last_of_item;
   logic               block_end;

   modport source (output valid, sample_out, code_byte_out, last_of_item, block_end,
                   input ready);
   modport sink   (input valid, sample_out, code_byte_out, last_of_item, block_end,
                   output ready);
endinterface

// File: sv/g726_fmul.sv
// Shared product unit: 16-bit coefficient times 11-bit float, two-stage pipeline.
// Depends on g726_pkg for the request/answer structs and bit_len.
module g726_fmul (
   input  logic                   clock,
   input  logic                   reset,
   input  g726_pkg::fmul_req_type req_in,
   output g726_pkg::fmul_rsp_type rsp_out
);
   import g726_pkg::*;

   logic               valid_ff, valid_in;
   logic [2:0]         tag_ff, tag_in;
   logic [7:0]         wmant_ff, wmant_in;
   logic signed [5:0]  wexp_ff, wexp_in;
   logic               neg_ff, neg_in;

   logic signed [13:0] an;
   logic [12:0]        anmag;
   logic [3:0]         e;
   logic [18:0]        norm;
   logic [5:0]         anmant;
   logic [11:0]        mprod;
   logic [12:0]        mround;
   logic signed [6:0]  wexp_w;
   logic [16:0]        up;
   logic [5:0]         nsh;
   logic [14:0]        rmag;

   // Normalize the coefficient and multiply mantissas
   always_comb begin
      an     = req_in.coef[15:2];
      anmag  = (an > 0) ? an[12:0] : 13'(-an);
      e      = bit_len({3'b0, anmag});
      norm   = {anmag, 6'b0} >> e;
      anmant = (anmag == '0) ? 6'd32 : norm[5:0];
      mprod  = anmant * req_in.fl[5:0];
      mround = {1'b0, mprod} + 13'd48;
      wexp_w = $signed({3'b0, e}) + $signed({3'b0, req_in.fl[9:6]}) - 7'sd19;
      valid_in = req_in.valid;
      tag_in   = req_in.tag;
      wmant_in = mround[11:4];
      wexp_in  = wexp_w[5:0];
      neg_in   = an[13] ^ req_in.fl[10];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      tag_ff   <= tag_in;
      wmant_ff <= wmant_in;
      wexp_ff  <= wexp_in;
      neg_ff   <= neg_in;
   end

   // Scale by the exponent and apply the sign
   always_comb begin
      up  = {9'b0, wmant_ff} << wexp_ff[3:0];
      nsh = 6'(-wexp_ff);
      if (!wexp_ff[5]) rmag = up[14:0];
      else rmag = 15'({7'b0, wmant_ff} >> nsh);
      rsp_out.valid = valid_ff;
      rsp_out.tag   = tag_ff;
      rsp_out.prod  = neg_ff ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
   end

endmodule

// File: sv/g726_adpcm_codec_unit.sv
// Top level of the G.726 32 kbit/s ADPCM codec: sequencer, predictor state and result register.
// Depends on g726_pkg, g726_if and g726_fmul.
//
// One item is taken at a time. Each 4-bit code runs through a sequencer that issues the eight
// predictor products to one shared product unit, then steps through scale, quantize (encode
// only), reconstruct and the adaptation states ADP1 and ADP2. A decode item turns two codes into
// two samples and an encode item turns two samples into one byte; the sequencer waits in EMIT
// while the result register is still full. Ready is high only while the sequencer is idle; a
// finished result waits in the output register without holding up the next item.
module g726_adpcm_codec_unit (
   input logic      clock,
   input logic      reset,
   input logic      csr_wr_en,
   input logic      csr_wr_data,
   g726_req_if.sink   req,
   g726_rsp_if.source rsp
);
   import g726_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_PRED  = 8'b0000_0010,
      ST_STEP  = 8'b0000_0100,
      ST_QUANT = 8'b0000_1000,
      ST_RECON = 8'b0001_0000,
      ST_ADP1  = 8'b0010_0000,
      ST_ADP2  = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic               mode_ff, mode_in;
   logic               half_ff, half_in;
   logic [7:0]         byte_ff, byte_in;
   logic signed [15:0] samp0_ff, samp0_in, samp1_ff, samp1_in;
   logic               eob_ff, eob_in;
   logic [3:0]         pcnt_ff, pcnt_in;
   logic signed [15:0] acc_ff, acc_in, sezi_ff, sezi_in, sei_ff, sei_in;
   logic [12:0]        y_ff, y_in;
   logic [3:0]         code_ff, code_in, code_lo_ff, code_lo_in;
   logic [14:0]        mag_ff, mag_in;
   logic signed [16:0] sr_ff, sr_in, dqsez_ff, dqsez_in;
   logic               tr_ff, tr_in, pks1_ff, pks1_in;

   logic [18:0]        slow_ff, slow_in;
   logic [12:0]        fast_ff, fast_in;
   logic [11:0]        sm_ff, sm_in;
   logic [13:0]        lm_ff, lm_in;
   logic [9:0]         speed_ff, speed_in;
   logic signed [15:0] a1_ff, a1_in, a2_ff, a2_in;
   logic signed [15:0] zc_ff [6];
   logic signed [15:0] zc_in [6];
   logic [10:0]        pdf_ff [6];
   logic [10:0]        pdf_in [6];
   logic [10:0]        prf_ff [2];
   logic [10:0]        prf_in [2];
   logic [1:0]         psb_ff, psb_in;
   logic               tone_ff, tone_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic [7:0]         rsp_code_ff, rsp_code_in;
   logic               rsp_last_ff, rsp_last_in, rsp_eob_ff, rsp_eob_in;

   fmul_req_type       freq;
   fmul_rsp_type       frsp;

   g726_fmul u_fmul (
      .clock   (clock),
      .reset   (reset),
      .req_in  (freq),
      .rsp_out (frsp)
   );

   // Issue the six zero and two pole products in turn
   always_comb begin
      freq.valid = (state_ff == ST_PRED) && !pcnt_ff[3];
      freq.tag   = pcnt_ff[2:0];
      if (pcnt_ff[2:0] == TAG_LAST) begin
         freq.coef = a1_ff;
         freq.fl   = prf_ff[0];
      end else if (pcnt_ff[2:0] == 3'd6) begin
         freq.coef = a2_ff;
         freq.fl   = prf_ff[1];
      end else begin
         freq.coef = zc_ff[pcnt_ff[2:0]];
         freq.fl   = pdf_ff[pcnt_ff[2:0]];
      end
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.sample_out    = rsp_sample_ff;
   assign rsp.code_byte_out = rsp_code_ff;
   assign rsp.last_of_item  = rsp_last_ff;
   assign rsp.block_end     = rsp_eob_ff;

   // Datapath terms
   logic signed [15:0] acc_sum;
   logic signed [14:0] se, sez, sl;
   logic [12:0]        y0, y_calc;
   logic signed [13:0] dif;
   logic signed [20:0] yprod, yround;
   logic signed [14:0] ysum;
   logic signed [15:0] d;
   logic [15:0]        dqm;
   logic [3:0]         ex;
   logic [22:0]        dqsh;
   logic [10:0]        dl;
   logic signed [12:0] dln;
   logic [2:0]         qi;
   logic               qgo;
   logic [3:0]         qcode;
   logic signed [11:0] dqln;
   logic signed [12:0] dql;
   logic [14:0]        dqt_sh, mag_calc;
   logic               dqs;
   logic signed [16:0] sr_calc, dqsez_calc, sign_mag;
   logic [15:0]        thr2;
   logic [16:0]        dqthr;
   logic               tr;
   logic signed [11:0] wi;
   logic signed [16:0] wt, yu;
   logic [12:0]        yu_c;
   logic signed [20:0] ns, slow_sum;
   logic               pk0, pks1;
   logic signed [16:0] a1e, a2e, a2p, fa1, ze, zb, a0, a1ul;
   logic [11:0]        fi12;
   logic signed [12:0] smd;
   logic signed [14:0] lmd, dd;
   logic [14:0]        ddabs;
   logic               tone_new, speed_up;
   logic [10:0]        sp_gap;
   logic [10:0]        sp_down;

   always_comb begin
      acc_sum = acc_ff + frsp.prod;
      se      = sei_ff[15:1];
      sez     = sezi_ff[15:1];

      // Blend fast and slow scale factors by the speed control
      y0     = slow_ff[18:6];
      dif    = $signed({1'b0, fast_ff}) - $signed({1'b0, y0});
      yprod  = dif * $signed({1'b0, speed_ff[7:2]});
      yround = yprod + ((dif < 0) ? 21'sd63 : 21'sd0);
      ysum   = $signed({2'b0, y0}) + 15'(yround >>> 6);
      y_calc = (speed_ff[9:8] != 2'b0) ? fast_ff : ysum[12:0];

      // Quantize the prediction error
      sl    = half_ff ? samp1_ff[15:1] : samp0_ff[15:1];
      d     = $signed({sl[14], sl}) - $signed({se[14], se});
      dqm   = (d < 0) ? 16'(-d) : 16'(d);
      ex    = bit_len({1'b0, dqm[15:1]});
      dqsh  = {dqm, 7'b0} >> ex;
      dl    = {ex, 7'b0} + {4'b0, dqsh[6:0]};
      dln   = $signed({2'b0, dl}) - $signed({2'b0, y_ff[12:2]});
      qi    = '0;
      qgo   = 1'b1;
      for (int k = 0; k < 7; k++) begin
         if (qgo && (dln >= qtab_val(3'(k)))) qi = 3'(k + 1);
         else qgo = 1'b0;
      end
      if (d < 0) qcode = 4'(4'd15 - {1'b0, qi});
      else if (qi == '0) qcode = 4'd15;
      else qcode = {1'b0, qi};

      // Reconstruct the quantized difference and the signal
      dqs      = code_ff[3];
      dqln     = dqln_val(code_ff);
      dql      = $signed({dqln[11], dqln}) + $signed({2'b0, y_ff[12:2]});
      dqt_sh   = {1'b1, dql[6:0], 7'b0} >> (4'd14 - dql[10:7]);
      mag_calc = (dql < 0) ? '0 : dqt_sh;
      sign_mag = dqs ? -$signed({2'b0, mag_calc}) : $signed({2'b0, mag_calc});
      sr_calc    = $signed({{2{se[14]}}, se}) + sign_mag;
      dqsez_calc = $signed({{2{sez[14]}}, sez}) + sign_mag;

      // Tone transition check
      if (slow_ff[18:15] > 4'd9) thr2 = 16'd31744;
      else thr2 = 16'({10'd0, 1'b1, slow_ff[14:10]} << slow_ff[18:15]);
      dqthr = ({1'b0, thr2} + {2'b0, thr2[15:1]}) >> 1;
      tr    = tone_ff && ({2'b0, mag_ff} > dqthr);

      // Scale factor adaptation
      wi = wi_val(code_ff);
      wt = $signed({wi, 5'b0}) - $signed({4'b0, y_ff});
      yu = $signed({4'b0, y_ff}) + (wt >>> 5);
      if (yu < $signed({4'b0, Y_MIN})) yu_c = Y_MIN;
      else if (yu > $signed({4'b0, Y_MAX})) yu_c = Y_MAX;
      else yu_c = yu[12:0];
      ns       = -$signed({2'b0, slow_ff});
      slow_sum = $signed({2'b0, slow_ff}) + $signed({8'b0, yu_c}) + (ns >>> 6);

      // Second pole coefficient
      pk0  = dqsez_ff[16];
      pks1 = pk0 ^ psb_ff[0];
      a1e  = {a1_ff[15], a1_ff};
      a2e  = {a2_ff[15], a2_ff};
      a2p  = a2e - (a2e >>> 7);
      fa1  = pks1 ? a1e : -a1e;
      if (dqsez_ff != 0) begin
         if (fa1 < -17'sd8191) a2p = a2p - 17'sd256;
         else if (fa1 > 17'sd8191) a2p = a2p + 17'sd255;
         else a2p = a2p + (fa1 >>> 5);
         if (pk0 ^ psb_ff[1]) begin
            if (a2p <= -17'sd12160) a2p = -17'sd12288;
            else if (a2p >= 17'sd12416) a2p = 17'sd12288;
            else a2p = a2p - 17'sd128;
         end else begin
            if (a2p <= -17'sd12416) a2p = -17'sd12288;
            else if (a2p >= 17'sd12160) a2p = 17'sd12288;
            else a2p = a2p + 17'sd128;
         end
      end

      // Short and long means of F(I)
      fi12 = fi_val(code_ff);
      smd  = $signed({1'b0, fi12}) - $signed({1'b0, sm_ff});
      lmd  = $signed({1'b0, fi12, 2'b0}) - $signed({1'b0, lm_ff});

      // First pole coefficient, bounded by the second (already updated)
      a0 = a1e - (a1e >>> 8);
      if (dqsez_ff != 0) a0 = a0 + (pks1_ff ? -17'sd192 : 17'sd192);
      a1ul = 17'sd15360 - a2e;
      if (a0 < -a1ul) a0 = -a1ul;
      else if (a0 > a1ul) a0 = a1ul;

      // Speed control from the updated means
      tone_new = !tr_ff && (a2_ff < -16'sd11776);
      dd       = $signed({1'b0, sm_ff, 2'b0}) - $signed({1'b0, lm_ff});
      ddabs    = (dd < 0) ? 15'(-dd) : 15'(dd);
      speed_up = (y_ff < 13'd1536) || tone_new || (ddabs >= {4'b0, lm_ff[13:3]});
      sp_gap   = 11'd512 - {1'b0, speed_ff};
      sp_down  = ({1'b0, speed_ff} + 11'd15) >> 4;
   end

   // Sequencer and state updates
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      half_in    = half_ff;
      byte_in    = byte_ff;
      samp0_in   = samp0_ff;
      samp1_in   = samp1_ff;
      eob_in     = eob_ff;
      pcnt_in    = pcnt_ff;
      acc_in     = acc_ff;
      sezi_in    = sezi_ff;
      sei_in     = sei_ff;
      y_in       = y_ff;
      code_in    = code_ff;
      code_lo_in = code_lo_ff;
      mag_in     = mag_ff;
      sr_in      = sr_ff;
      dqsez_in   = dqsez_ff;
      tr_in      = tr_ff;
      pks1_in    = pks1_ff;
      slow_in    = slow_ff;
      fast_in    = fast_ff;
      sm_in      = sm_ff;
      lm_in      = lm_ff;
      speed_in   = speed_ff;
      a1_in      = a1_ff;
      a2_in      = a2_ff;
      zc_in      = zc_ff;
      pdf_in     = pdf_ff;
      prf_in     = prf_ff;
      psb_in     = psb_ff;
      tone_in    = tone_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_eob_in    = rsp_eob_ff;
      ze = '0;
      zb = '0;

      if (csr_wr_en) mode_in = csr_wr_data;

      unique case (state_ff)
         ST_IDLE: begin
            // Take an item and optionally reload the predictor
            if (req.valid) begin
               byte_in  = req.code_byte;
               samp0_in = req.sample_first;
               samp1_in = req.sample_second;
               eob_in   = req.end_of_block;
               half_in  = 1'b0;
               pcnt_in  = '0;
               acc_in   = '0;
               state_in = ST_PRED;
               if (req.restart) begin
                  slow_in  = SLOW_RESET;
                  fast_in  = FAST_RESET;
                  sm_in    = '0;
                  lm_in    = '0;
                  speed_in = '0;
                  a1_in    = '0;
                  a2_in    = '0;
                  psb_in   = '0;
                  tone_in  = 1'b0;
                  for (int c = 0; c < 6; c++) begin
                     zc_in[c]  = '0;
                     pdf_in[c] = FLOAT_ONE;
                  end
                  prf_in[0] = FLOAT_ONE;
                  prf_in[1] = FLOAT_ONE;
               end
            end
         end
         ST_PRED: begin
            // Accumulate products modulo 2^16
            if (freq.valid) pcnt_in = pcnt_ff + 4'd1;
            if (frsp.valid) begin
               acc_in = acc_sum;
               if (frsp.tag == TAG_LAST_ZERO) sezi_in = acc_sum;
               if (frsp.tag == TAG_LAST) begin
                  sei_in   = acc_sum;
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            y_in     = y_calc;
            code_in  = half_ff ? byte_ff[7:4] : byte_ff[3:0];
            state_in = mode_ff ? ST_QUANT : ST_RECON;
         end
         ST_QUANT: begin
            code_in  = qcode;
            state_in = ST_RECON;
         end
         ST_RECON: begin
            mag_in   = mag_calc;
            sr_in    = sr_calc;
            dqsez_in = dqsez_calc;
            state_in = ST_ADP1;
         end
         ST_ADP1: begin
            tr_in   = tr;
            pks1_in = pks1;
            fast_in = yu_c;
            slow_in = slow_sum[18:0];
            a2_in   = tr ? 16'sd0 : a2p[15:0];
            for (int c = 0; c < 6; c++) begin
               ze = {zc_ff[c][15], zc_ff[c]};
               zb = ze - (ze >>> 8);
               if (mag_ff != '0) zb = zb + ((dqs == pdf_ff[c][10]) ? 17'sd128 : -17'sd128);
               zc_in[c] = tr ? 16'sd0 : zb[15:0];
            end
            for (int c = 5; c > 0; c--) pdf_in[c] = pdf_ff[c - 1];
            pdf_in[0] = to_float(mag_ff, dqs);
            prf_in[1] = prf_ff[0];
            if (!sr_ff[16]) prf_in[0] = to_float(sr_ff[14:0], 1'b0);
            else prf_in[0] = to_float(15'(-sr_ff), 1'b1);
            psb_in = {psb_ff[0], pk0};
            sm_in  = 12'($signed({1'b0, sm_ff}) + (smd >>> 5));
            lm_in  = 14'($signed({1'b0, lm_ff}) + (lmd >>> 7));
            state_in = ST_ADP2;
         end
         ST_ADP2: begin
            a1_in   = tr_ff ? 16'sd0 : a0[15:0];
            tone_in = tone_new;
            if (tr_ff) speed_in = SPEED_TONE;
            else if (speed_up) speed_in = 10'({1'b0, speed_ff} + (sp_gap >> 4));
            else speed_in = 10'({1'b0, speed_ff} - sp_down);
            if (mode_ff && !half_ff) begin
               code_lo_in = code_ff;
               half_in    = 1'b1;
               pcnt_in    = '0;
               acc_in     = '0;
               state_in   = ST_PRED;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Load the result register once it is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               if (mode_ff) begin
                  rsp_sample_in = '0;
                  rsp_code_in   = {code_ff, code_lo_ff};
                  rsp_last_in   = 1'b1;
                  rsp_eob_in    = eob_ff;
               end else begin
                  rsp_sample_in = {sr_ff[14:0], 1'b0};
                  rsp_code_in   = '0;
                  rsp_last_in   = half_ff;
                  rsp_eob_in    = half_ff & eob_ff;
               end
               if (!mode_ff && !half_ff) begin
                  half_in  = 1'b1;
                  pcnt_in  = '0;
                  acc_in   = '0;
                  state_in = ST_PRED;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         half_ff      <= 1'b0;
         pcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         slow_ff      <= SLOW_RESET;
         fast_ff      <= FAST_RESET;
         sm_ff        <= '0;
         lm_ff        <= '0;
         speed_ff     <= '0;
         a1_ff        <= '0;
         a2_ff        <= '0;
         psb_ff       <= '0;
         tone_ff      <= 1'b0;
         for (int c = 0; c < 6; c++) begin
            zc_ff[c]  <= '0;
            pdf_ff[c] <= FLOAT_ONE;
         end
         prf_ff[0] <= FLOAT_ONE;
         prf_ff[1] <= FLOAT_ONE;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         half_ff      <= half_in;
         pcnt_ff      <= pcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         slow_ff      <= slow_in;
         fast_ff      <= fast_in;
         sm_ff        <= sm_in;
         lm_ff        <= lm_in;
         speed_ff     <= speed_in;
         a1_ff        <= a1_in;
         a2_ff        <= a2_in;
         psb_ff       <= psb_in;
         tone_ff      <= tone_in;
         zc_ff        <= zc_in;
         pdf_ff       <= pdf_in;
         prf_ff       <= prf_in;
      end
      byte_ff       <= byte_in;
      samp0_ff      <= samp0_in;
      samp1_ff      <= samp1_in;
      eob_ff        <= eob_in;
      acc_ff        <= acc_in;
      sezi_ff       <= sezi_in;
      sei_ff        <= sei_in;
      y_ff          <= y_in;
      code_ff       <= code_in;
      code_lo_ff    <= code_lo_in;
      mag_ff        <= mag_in;
      sr_ff         <= sr_in;
      dqsez_ff      <= dqsez_in;
      tr_ff         <= tr_in;
      pks1_ff       <= pks1_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_eob_ff    <= rsp_eob_in;
   end

endmodule

// File: sv/g726_checker.sv
// Port-level checks for the codec top level, attached by the bind below.
// Depends only on the top level's ports.
module g726_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_sample_out,
   input logic [7:0]  rsp_code_byte_out,
   input logic        rsp_last_of_item,
   input logic        rsp_block_end
);

   // One item at a time: busy right after an accept
   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an accepted item");

   // A stalled result holds
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
                                  && $stable(rsp_code_byte_out))
      else $error("stalled result changed");

   // Block end only on an item's final result
   eob_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |-> rsp_last_of_item)
      else $error("block end without last of item");

   // Only one of the mode's payloads is populated
   one_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sample_out != 16'd0) |-> rsp_code_byte_out == 8'd0)
      else $error("both sample and code byte set");

   // Nothing pending right after reset
   reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind g726_adpcm_codec_unit g726_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_sample_out    (rsp.sample_out),
   .rsp_code_byte_out (rsp.code_byte_out),
   .rsp_last_of_item  (rsp.last_of_item),
   .rsp_block_end     (rsp.block_end)
);

// File: dv/g726_adpcm_codec_unit_test.sv
// Self-checking testbench for the G.726 32 kbit/s ADPCM codec top level.
// Depends on g726_pkg, g726_if and the codec RTL; a built-in predictor computes each result.
module g726_adpcm_codec_unit_test;
   import g726_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 64;
   localparam bit MODE_DECODE    = 1'b0;
   localparam bit MODE_ENCODE    = 1'b1;

   localparam int DQLN_TAB [16] = '{-2048, 4, 135, 213, 273, 323, 373, 425,
                                    425, 373, 323, 273, 213, 135, 4, -2048};
   localparam int WI_TAB [16]   = '{-12, 18, 41, 64, 112, 198, 355, 1122,
                                    1122, 355, 198, 112, 64, 41, 18, -12};
   localparam int FI_TAB [16]   = '{0, 0, 0, 'h200, 'h200, 'h200, 'h600, 'hE00,
                                    'hE00, 'h600, 'h200, 'h200, 'h200, 0, 0, 0};
   localparam int QTAB [7]      = '{-124, 80, 178, 246, 300, 349, 400};

   typedef struct {
      logic [15:0] sample;
      logic [7:0]  code_byte;
      logic        last;
      logic        blk_end;
   } codec_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   g726_req_if req ();
   g726_rsp_if rsp ();

   g726_adpcm_codec_unit dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req(req.sink), .rsp(rsp.source)
   );

   always #4 clock = ~clock;

   // Predictor state and the expected results still to come
   bit codec_enc;
   int slow_s, fast_s, short_mm, long_mm, speed;
   int pole [2];
   int zcoef [6];
   int diff_fl [6];
   int recon_fl [2];
   int sign_hist [2];
   int tone;
   codec_result_t pending_results [$];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  fail_count = 0;
   int  idle_cycles = 0;

   function automatic int wrap16(int v);
      return {{16{v[15]}}, v[15:0]};
   endfunction

   function automatic int len_of(int v);
      int e;
      e = 0;
      while (e < 15 && v >= (1 << e)) e++;
      return e;
   endfunction

   function automatic void clear_predictor();
      slow_s = 34816; fast_s = 544; short_mm = 0; long_mm = 0; speed = 0;
      for (int k = 0; k < 2; k++) begin
         pole[k] = 0; recon_fl[k] = 32; sign_hist[k] = 0;
      end
      for (int k = 0; k < 6; k++) begin
         zcoef[k] = 0; diff_fl[k] = 32;
      end
      tone = 0;
   endfunction

   // Coefficient times 11-bit float
   function automatic int coef_times_float(int coef, int fl);
      int an, anmag, anexp, anmant, wexp, wmant, r;
      bit neg;
      an = coef >>> 2;
      anmag = an > 0 ? an : ((-an) & 'h1FFF);
      anexp = len_of(anmag) - 6;
      anmant = anmag == 0 ? 32 : (anexp >= 0 ? (anmag >> anexp) : (anmag << (-anexp)));
      wexp = anexp + ((fl >> 6) & 15) - 13;
      wmant = (anmant * (fl & 63) + 'h30) >> 4;
      r = wexp >= 0 ? ((wmant << wexp) & 'h7FFF) : (wmant >> (-wexp));
      neg = (an < 0) != (((fl >> 10) & 1) != 0);
      return neg ? -r : r;
   endfunction

   function automatic int mag_to_float(int mag, bit neg);
      int f, e;
      if (mag == 0) f = 'h20;
      else begin
         e = len_of(mag);
         f = (e << 6) + ((mag << 6) >> e);
      end
      return neg ? (f | 'h400) : f;
   endfunction

   function automatic int scale_now();
      int y, dif, al;
      if (speed >= 256) return fast_s;
      y = slow_s >> 6; dif = fast_s - y; al = speed >> 2;
      if (dif > 0) y += (dif * al) >> 6;
      else if (dif < 0) y += (dif * al + 63) >>> 6;
      return y;
   endfunction

   function automatic int dequant_mag(int dqln, int y);
      int dql, dex, dqt;
      dql = dqln + (y >> 2);
      if (dql < 0) return 0;
      dex = (dql >> 7) & 15;
      dqt = 128 + (dql & 127);
      if (dex > 14) return ((dqt << 7) << (dex - 14)) & 'h7FFF;
      return (dqt << 7) >> (14 - dex);
   endfunction

   // Update scales, coefficients, histories, tone and speed control
   function automatic void adapt_state(int y, int code, int dqs, int mag, int sr, int dqsez);
      int pk0, ylint, ylfrac, thr2, dqthr, yu, a2p, fa1, pks1, a1ul, fi, a0, b, dd;
      bit tr;
      pk0 = dqsez < 0 ? 1 : 0;
      a2p = 0;
      ylint = slow_s >> 15;
      ylfrac = (slow_s >> 10) & 'h1F;
      thr2 = ylint > 9 ? (31 << 10) : ((32 + ylfrac) << ylint);
      dqthr = (thr2 + (thr2 >> 1)) >> 1;
      tr = tone != 0 && mag > dqthr;
      yu = y + ((WI_TAB[code] * 32 - y) >>> 5);
      if (yu < 544) yu = 544;
      else if (yu > 5120) yu = 5120;
      fast_s = yu;
      slow_s = (slow_s + yu + ((-slow_s) >>> 6)) & 'h7FFFF;
      if (tr) begin
         pole[0] = 0; pole[1] = 0;
         for (int c = 0; c < 6; c++) zcoef[c] = 0;
      end else begin
         pks1 = pk0 ^ sign_hist[0];
         a2p = pole[1] - (pole[1] >>> 7);
         if (dqsez != 0) begin
            fa1 = pks1 ? pole[0] : -pole[0];
            if (fa1 < -8191) a2p -= 'h100;
            else if (fa1 > 8191) a2p += 'hFF;
            else a2p += fa1 >>> 5;
            if (pk0 ^ sign_hist[1]) begin
               if (a2p <= -12160) a2p = -12288;
               else if (a2p >= 12416) a2p = 12288;
               else a2p -= 'h80;
            end else begin
               if (a2p <= -12416) a2p = -12288;
               else if (a2p >= 12160) a2p = 12288;
               else a2p += 'h80;
            end
         end
         pole[1] = a2p;
         a0 = pole[0] - (pole[0] >>> 8);
         if (dqsez != 0) a0 += pks1 == 0 ? 192 : -192;
         a1ul = 15360 - a2p;
         if (a0 < -a1ul) a0 = -a1ul;
         else if (a0 > a1ul) a0 = a1ul;
         pole[0] = a0;
         for (int c = 0; c < 6; c++) begin
            b = zcoef[c] - (zcoef[c] >>> 8);
            if (mag != 0) b += (dqs == ((diff_fl[c] >> 10) & 1)) ? 128 : -128;
            zcoef[c] = wrap16(b);
         end
      end
      for (int c = 5; c > 0; c--) diff_fl[c] = diff_fl[c - 1];
      diff_fl[0] = mag_to_float(mag, dqs != 0);
      recon_fl[1] = recon_fl[0];
      if (sr >= 0) recon_fl[0] = mag_to_float(sr, 1'b0);
      else recon_fl[0] = mag_to_float((-sr) & 'h7FFF, 1'b1);
      sign_hist[1] = sign_hist[0];
      sign_hist[0] = pk0;
      tone = tr ? 0 : (a2p < -11776 ? 1 : 0);
      fi = FI_TAB[code];
      short_mm += (fi - short_mm) >>> 5;
      long_mm += ((fi << 2) - long_mm) >>> 7;
      if (tr) speed = 256;
      else begin
         dd = (short_mm << 2) - long_mm;
         if (dd < 0) dd = -dd;
         if (y < 1536 || tone != 0 || dd >= (long_mm >> 3)) speed += ('h200 - speed) >> 4;
         else speed += (-speed) >>> 4;
      end
   endfunction

   // One code through the predictor; a negative code quantizes the sample sl
   function automatic int code_step(int code, int sl, output int sr);
      int sezi, sei, sez, se, y, mag, d, dqm, ex, dl, dln, i, dqs;
      sezi = 0;
      for (int c = 0; c < 6; c++) sezi += coef_times_float(zcoef[c], diff_fl[c]);
      sezi = wrap16(sezi);
      sei = wrap16(sezi + coef_times_float(pole[1], recon_fl[1])
                   + coef_times_float(pole[0], recon_fl[0]));
      sez = sezi >>> 1;
      se = sei >>> 1;
      y = scale_now();
      if (code < 0) begin
         d = sl - se;
         dqm = d < 0 ? -d : d;
         ex = len_of(dqm >> 1);
         dl = (ex << 7) + (((dqm << 7) >> ex) & 'h7F);
         dln = dl - (y >> 2);
         i = 0;
         while (i < 7 && dln >= QTAB[i]) i++;
         code = d < 0 ? 15 - i : (i == 0 ? 15 : i);
      end
      code &= 15;
      dqs = (code >> 3) & 1;
      mag = dequant_mag(DQLN_TAB[code], y);
      sr = dqs ? se - (mag & 'h3FFF) : se + mag;
      adapt_state(y, code, dqs, mag, sr, (dqs ? -mag : mag) + sez);
      return code;
   endfunction

   // Queue the results an accepted item causes
   function automatic void predict_item(logic [7:0] cbyte, logic signed [15:0] s1,
                                        logic signed [15:0] s2, logic rst, logic eob);
      int sr, lo, hi, sr_w;
      codec_result_t r;
      if (rst) clear_predictor();
      if (codec_enc == MODE_DECODE) begin
         for (int k = 0; k < 2; k++) begin
            void'(code_step((cbyte >> (4 * k)) & 15, 0, sr));
            sr_w = sr << 1;
            r.sample = sr_w[15:0];
            r.code_byte = '0;
            r.last = k == 1;
            r.blk_end = k == 1 ? eob : 1'b0;
            pending_results.push_back(r);
         end
      end else begin
         lo = code_step(-1, int'(s1) >>> 1, sr);
         hi = code_step(-1, int'(s2) >>> 1, sr);
         r.sample = '0;
         r.code_byte = {hi[3:0], lo[3:0]};
         r.last = 1'b1;
         r.blk_end = eob;
         pending_results.push_back(r);
      end
   endfunction

   // Drive one item, hold it until accepted
   task automatic send_item(logic [7:0] cbyte, logic signed [15:0] s1, logic signed [15:0] s2,
                            logic rst, logic eob);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.code_byte <= cbyte;
      req.sample_first <= s1;
      req.sample_second <= s2;
      req.restart <= rst;
      req.end_of_block <= eob;
      do @(posedge clock); while (!req.ready);
      predict_item(cbyte, s1, s2, rst, eob);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write the mode register while idle
   task automatic set_mode(bit m);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      codec_enc = m;
   endtask

   task automatic test_decode_directed();
      set_mode(MODE_DECODE);
      send_item(8'h00, 16'sh7FFF, -16'sd1, 1'b0, 1'b0);
      send_item(8'hFF, 16'sh0, 16'sh0, 1'b0, 1'b1);
      send_item(8'h0F, 16'sh0, 16'sh0, 1'b0, 1'b0);
      send_item(8'hF0, 16'sh0, 16'sh0, 1'b0, 1'b0);
      // every code, low then high nibble
      for (int k = 0; k < 8; k++) send_item(8'((2 * k + 1) << 4 | 2 * k), '0, '0, 1'b0, 1'b0);
      send_item(8'h77, '0, '0, 1'b1, 1'b1);
      send_item(8'h88, '0, '0, 1'b0, 1'b0);
   endtask

   task automatic test_encode_directed();
      set_mode(MODE_ENCODE);
      send_item(8'hFF, 16'sh7FFF, -16'sh8000, 1'b0, 1'b0);
      send_item(8'h00, -16'sh8000, 16'sh7FFF, 1'b0, 1'b1);
      send_item(8'h00, 16'sh0, -16'sd1, 1'b1, 1'b0);
      send_item(8'h00, 16'sd1, 16'sd0, 1'b0, 1'b0);
      send_item(8'h00, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
      send_item(8'h00, -16'sh8000, -16'sh8000, 1'b0, 1'b1);
      // mode switch keeps state: decode right after encode
      set_mode(MODE_DECODE);
      send_item(8'h5A, '0, '0, 1'b0, 1'b1);
   endtask

   // Mostly smooth waveforms, with noise, full-range jumps and restarts
   task automatic test_random_stream(bit m, int count);
      int phase, amp, step, a, b;
      set_mode(m);
      phase = 0;
      amp = $urandom_range(32767);
      step = $urandom_range(1, 800);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 80) begin
            phase += step;
            a = ((phase & 'hFFFF) < 'h8000) ? (phase & 'h7FFF) : ('h7FFF - (phase & 'h7FFF));
            a = ((a - 16384) * amp) >>> 14;
            phase += step;
            b = ((phase & 'hFFFF) < 'h8000) ? (phase & 'h7FFF) : ('h7FFF - (phase & 'h7FFF));
            b = ((b - 16384) * amp) >>> 14;
            a += $urandom_range(64) - 32;
            b += $urandom_range(64) - 32;
            if (a > 32767) a = 32767;
            if (a < -32768) a = -32768;
            if (b > 32767) b = 32767;
            if (b < -32768) b = -32768;
         end else begin
            a = $urandom;
            b = $urandom;
            a = wrap16(a);
            b = wrap16(b);
         end
         if ($urandom_range(99) < 5) begin
            amp = $urandom_range(32767);
            step = $urandom_range(1, 800);
         end
         send_item(8'($urandom), 16'(a), 16'(b), $urandom_range(99) < 2,
                   $urandom_range(99) < 10);
      end
   endtask

   task automatic test_random_all_idling(int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      test_random_stream(MODE_DECODE, 250);
      test_random_stream(MODE_ENCODE, 250);
   endtask

   // Randomly stall the result side
   always @(negedge clock) begin
      rsp.ready <= $urandom_range(99) >= recv_stall_pct;
   end

   // Check each result against the oldest expectation; watch for a hang
   always @(posedge clock) begin
      codec_result_t e;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("g726_adpcm_codec_unit: mismatch");
            $finish;
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result sample %h byte %h", $time,
                        rsp.sample_out, rsp.code_byte_out);
               fail_count++;
            end else begin
               e = pending_results.pop_front();
               if (rsp.sample_out !== e.sample) begin
                  $display("%0t: sample_out expected %h actual %h", $time, e.sample,
                           rsp.sample_out);
                  fail_count++;
               end
               if (rsp.code_byte_out !== e.code_byte) begin
                  $display("%0t: code_byte_out expected %h actual %h", $time, e.code_byte,
                           rsp.code_byte_out);
                  fail_count++;
               end
               if (rsp.last_of_item !== e.last) begin
                  $display("%0t: last_of_item expected %b actual %b", $time, e.last,
                           rsp.last_of_item);
                  fail_count++;
               end
               if (rsp.block_end !== e.blk_end) begin
                  $display("%0t: block_end expected %b actual %b", $time, e.blk_end,
                           rsp.block_end);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.code_byte = '0;
      req.sample_first = '0;
      req.sample_second = '0;
      req.restart = 1'b0;
      req.end_of_block = 1'b0;
      rsp.ready = 1'b0;
      codec_enc = MODE_DECODE;
      clear_predictor();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_decode_directed();
      test_encode_directed();
      test_random_all_idling(0, 0);
      test_random_all_idling(63, 0);
      test_random_all_idling(0, 63);
      test_random_all_idling(35, 35);
      wait_drained();
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("g726_adpcm_codec_unit: match");
      end else begin
         $display("g726_adpcm_codec_unit: mismatch");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/g726_pkg.sv
sv/g726_if.sv
sv/g726_fmul.sv
sv/g726_adpcm_codec_unit.sv
sv/g726_checker.sv
dv/g726_adpcm_codec_unit_test.sv
